// ===== src/osd_pkg.sv =====
// Shared constants, widths, command/status structs and the divider table
// for the oscillator divider search unit. No dependencies.
package osd_pkg;

   // Field widths.
   localparam int unsigned REQ_W    = 31;
   localparam int unsigned XTAL_W   = 27;
   localparam int unsigned HS_W     = 4;
   localparam int unsigned N1_W     = 8;
   localparam int unsigned RFREQ_W  = 38;
   localparam int unsigned REGW_W   = 48;
   localparam int unsigned HSF_W    = 35;   // request times high-speed divider
   localparam int unsigned FDCO_W   = 37;   // running oscillator frequency
   localparam int unsigned DIVD_W   = 33;   // oscillator frequency below the upper bound
   localparam int unsigned FRAC_W   = 28;   // fraction bits of the frequency word
   localparam int unsigned SAT_SH   = RFREQ_W - FRAC_W;
   localparam int unsigned CNT_W    = 6;
   localparam int unsigned IDX_W    = 3;

   // Stream widths.
   localparam int unsigned REQ_TDATA_W = 32;
   localparam int unsigned RSP_TDATA_W = 104;
   localparam int unsigned RSP_USED_W  = HS_W + N1_W + RFREQ_W + REGW_W;

   // Oscillator window and limits.
   localparam logic [FDCO_W-1:0]  FDCO_LOW   = 37'd4800000000;
   localparam logic [FDCO_W-1:0]  FDCO_HIGH  = 37'd5670000000;
   localparam logic [N1_W-1:0]    N1_LIMIT   = 8'd128;
   localparam logic [RFREQ_W-1:0] WORD_MAX   = {RFREQ_W{1'b1}};
   localparam logic [XTAL_W-1:0]  XTAL_RESET = 27'd114264401;
   localparam logic [IDX_W-1:0]   HS_LAST    = 3'd5;
   localparam logic [CNT_W-1:0]   DIV_STEPS  = 6'd38;
   localparam int unsigned        N1_SHIFT   = 7;    // 128 = 2**7

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load_req;
      logic             load_hs;
      logic [IDX_W-1:0] hs_idx;
      logic             step;
      logic             div_start;
      logic             load_out;
      logic             found;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_zero;
      logic over;
      logic hit;
      logic n1_last;
      logic hopeless;
      logic div_done;
      logic out_busy;
   } status_type;

   // High-speed divider in search order.
   function automatic logic [HS_W-1:0] hs_of(input logic [IDX_W-1:0] idx);
      logic [HS_W-1:0] val;
      unique case (idx)
         3'd0:    val = 4'd11;
         3'd1:    val = 4'd9;
         3'd2:    val = 4'd7;
         3'd3:    val = 4'd6;
         3'd4:    val = 4'd5;
         3'd5:    val = 4'd4;
         default: val = 4'd4;
      endcase
      return val;
   endfunction

endpackage

// ===== src/osd_div.sv =====
// Iterative restoring divider producing the saturated frequency word.
// Depends on osd_pkg.
module osd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [osd_pkg::DIVD_W-1:0]    dividend,
   input  logic [osd_pkg::XTAL_W-1:0]    divisor,
   output logic [osd_pkg::RFREQ_W-1:0]   quotient,
   output logic                          done
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [osd_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [osd_pkg::XTAL_W-1:0]    rem_ff, rem_in;
   logic [osd_pkg::RFREQ_W-1:0]   bits_ff, bits_in;
   logic [osd_pkg::RFREQ_W-1:0]   quo_ff, quo_in;
   logic                          sat;
   logic [osd_pkg::XTAL_W:0]      trial;
   logic                          take;

   // The word saturates when the quotient needs more than 38 bits, which
   // also covers a zero crystal.
   assign sat = ({{(osd_pkg::SAT_SH + osd_pkg::XTAL_W - osd_pkg::DIVD_W){1'b0}}, dividend}
                 >= {divisor, {osd_pkg::SAT_SH{1'b0}}});

   // One quotient bit per cycle.
   assign trial = {rem_ff, bits_ff[osd_pkg::RFREQ_W-1]};
   assign take  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      bits_in  = bits_ff;
      quo_in   = quo_ff;
      if (start) begin
         if (sat) begin
            quo_in  = osd_pkg::WORD_MAX;
            done_in = 1'b1;
         end else begin
            rem_in   = osd_pkg::XTAL_W'(dividend[osd_pkg::DIVD_W-1:osd_pkg::SAT_SH]);
            bits_in  = {dividend[osd_pkg::SAT_SH-1:0], {osd_pkg::FRAC_W{1'b0}}};
            count_in = osd_pkg::DIV_STEPS;
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in   = take ? osd_pkg::XTAL_W'(trial - {1'b0, divisor})
                         : trial[osd_pkg::XTAL_W-1:0];
         quo_in   = {quo_ff[osd_pkg::RFREQ_W-2:0], take};
         bits_in  = {bits_ff[osd_pkg::RFREQ_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      bits_ff  <= bits_in;
      quo_ff   <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== src/osd_dpath.sv =====
// Datapath: request and crystal registers, divider search arithmetic,
// frequency word divider and the result register. Depends on osd_pkg, osd_div.
module osd_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  osd_pkg::cmd_type                   cmd,
   output osd_pkg::status_type                status,
   input  logic [osd_pkg::REQ_W-1:0]          request_freq,
   input  logic                               csr_wr_en,
   input  logic [osd_pkg::XTAL_W-1:0]         csr_wr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [osd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tuser
);

   logic [osd_pkg::XTAL_W-1:0]  xtal_ff, xtal_in;
   logic [osd_pkg::REQ_W-1:0]   f_ff;
   logic [osd_pkg::HS_W-1:0]    hs_ff;
   logic [osd_pkg::HSF_W-1:0]   hsf_ff, hsf_in;
   logic [osd_pkg::FDCO_W-1:0]  fdco_ff, fdco_in;
   logic [osd_pkg::N1_W-1:0]    n1_ff, n1_in;
   logic [osd_pkg::HS_W-1:0]    hs_sel;
   logic [osd_pkg::RFREQ_W-1:0] quo;
   logic                        div_done;

   logic                        out_valid_ff;
   logic                        out_found_ff;
   logic [osd_pkg::HS_W-1:0]    out_hs_ff;
   logic [osd_pkg::N1_W-1:0]    out_n1_ff;
   logic [osd_pkg::RFREQ_W-1:0] out_rf_ff;
   logic [osd_pkg::REGW_W-1:0]  out_reg_ff;
   logic [osd_pkg::N1_W-1:0]    n1_m1;
   logic [7:0]                  reg7, reg8;

   // Crystal frequency register.
   assign xtal_in = csr_wr_en ? csr_wr_data : xtal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xtal_ff <= osd_pkg::XTAL_RESET;
      end else begin
         xtal_ff <= xtal_in;
      end
   end

   // Search arithmetic: the oscillator frequency is stepped by adding
   // request*hs once (N1 from 1 to 2) or twice (even N1).
   assign hs_sel = osd_pkg::hs_of(cmd.hs_idx);
   assign hsf_in = osd_pkg::HSF_W'(f_ff) * osd_pkg::HSF_W'(hs_sel);

   always_comb begin
      fdco_in = fdco_ff;
      n1_in   = n1_ff;
      if (cmd.load_hs) begin
         fdco_in = osd_pkg::FDCO_W'(hsf_in);
         n1_in   = 8'd1;
      end else if (cmd.step) begin
         if (n1_ff == 8'd1) begin
            fdco_in = fdco_ff + osd_pkg::FDCO_W'(hsf_ff);
            n1_in   = 8'd2;
         end else begin
            fdco_in = fdco_ff + osd_pkg::FDCO_W'({hsf_ff, 1'b0});
            n1_in   = n1_ff + 8'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         f_ff <= request_freq;
      end
      if (cmd.load_hs) begin
         hs_ff  <= hs_sel;
         hsf_ff <= hsf_in;
      end
      fdco_ff <= fdco_in;
      n1_ff   <= n1_in;
   end

   // Frequency word divider.
   osd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (fdco_ff[osd_pkg::DIVD_W-1:0]),
      .divisor  (xtal_ff),
      .quotient (quo),
      .done     (div_done)
   );

   // Register bytes 7 and 8 from the chosen dividers and the word.
   assign n1_m1 = n1_ff - 8'd1;
   assign reg7  = {3'(hs_ff - 4'd4), n1_m1[6:2]};
   assign reg8  = {n1_m1[1:0], quo[osd_pkg::RFREQ_W-1:32]};

   // Result register; a new result may be loaded as the old one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_found_ff <= cmd.found;
         out_hs_ff    <= cmd.found ? hs_ff : '0;
         out_n1_ff    <= cmd.found ? n1_ff : '0;
         out_rf_ff    <= cmd.found ? quo : '0;
         out_reg_ff   <= cmd.found ? {reg7, reg8, quo[31:0]} : '0;
      end
   end

   // Status toward the controller. The hopeless test is done at full width
   // so that a large request times divider cannot wrap below the window.
   assign status.req_zero = (f_ff == '0);
   assign status.over     = (fdco_ff > osd_pkg::FDCO_HIGH);
   assign status.hit      = (fdco_ff > osd_pkg::FDCO_LOW) && (fdco_ff < osd_pkg::FDCO_HIGH);
   assign status.n1_last  = (n1_ff == osd_pkg::N1_LIMIT);
   assign status.hopeless = ({hsf_ff, {osd_pkg::N1_SHIFT{1'b0}}}
                             <= {{(osd_pkg::HSF_W + osd_pkg::N1_SHIFT - osd_pkg::FDCO_W){1'b0}},
                                 osd_pkg::FDCO_LOW});
   assign status.div_done = div_done;
   assign status.out_busy = out_valid_ff && !rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_found_ff;
   assign rsp_tdata  = {{(osd_pkg::RSP_TDATA_W - osd_pkg::RSP_USED_W){1'b0}},
                        out_reg_ff, out_rf_ff, out_n1_ff, out_hs_ff};

endmodule

// ===== src/osd_ctrl.sv =====
// Controller state machine sequencing the divider search, the word
// division and the result hand-off. Depends on osd_pkg.
module osd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output osd_pkg::cmd_type      cmd,
   input  osd_pkg::status_type   status
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_HS_LOAD  = 3'd1;
   localparam logic [2:0] S_SEARCH   = 3'd2;
   localparam logic [2:0] S_DIV_WAIT = 3'd3;
   localparam logic [2:0] S_FINISH   = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [osd_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        found_ff, found_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      cmd           = '0;
      cmd.hs_idx    = idx_ff;
      cmd.found     = found_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               idx_in       = '0;
               found_in     = 1'b0;
               state_in     = S_HS_LOAD;
            end
         end
         S_HS_LOAD: begin
            if (status.req_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.load_hs = 1'b1;
               state_in    = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (status.over || status.hopeless ||
                         (!status.hit && status.n1_last)) begin
               // This divider is done; move to the next one or give up.
               if (idx_ff == osd_pkg::HS_LAST) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_HS_LOAD;
               end
            end else if (status.hit) begin
               cmd.div_start = 1'b1;
               found_in      = 1'b1;
               state_in      = S_DIV_WAIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!status.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
      end
   end

endmodule

// ===== src/oscillator_divider_search_unit.sv =====
// Top level of the oscillator divider search unit: controller plus datapath.
// Depends on osd_pkg, osd_ctrl, osd_dpath (and osd_div below it).
//
// Takes a requested output frequency and finds the first high-speed divider
// (11, 9, 7, 6, 5, 4) and output divider (1, then even up to 128) that put the
// oscillator strictly between 4.8 GHz and 5.67 GHz, then returns the dividers,
// the 38-bit frequency word (28 fraction bits, relative to the crystal
// register) and the packed device register bytes 7 to 12. One item is worked
// at a time. A zero request goes straight to the result register. Otherwise
// each divider tried first forms request*divider and then tests one output
// divider value per cycle until a hit, until the oscillator passes the window
// or divider 128 misses, or at once when 128 cannot reach the window; a hit
// starts the bit-serial word division, which gives the saturated word with no
// bit steps when the word saturates; the result register is then loaded. The
// request port opens again in the cycle after the result is loaded. A new
// item is taken while the previous result still waits in the output register;
// the next result is loaded only once that one is taken.
module oscillator_divider_search_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [osd_pkg::REQ_TDATA_W-1:0]       req_tdata,  // [30:0] request_freq
   // Result channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [3:0] hs_divider, [11:4] n1_divider, [49:12] rfreq_word, [97:50] reg_word
   output logic [osd_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser,  // [0] found
   // Crystal frequency register.
   input  logic                                  csr_wr_en,
   input  logic [osd_pkg::XTAL_W-1:0]            csr_wr_data
);

   osd_pkg::cmd_type    cmd;
   osd_pkg::status_type status;

   osd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   osd_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .request_freq (req_tdata[osd_pkg::REQ_W-1:0]),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule
